/* src/bxd_pkg.sv */
// ----------------------------------------------------------------------------
// bxd_pkg
// Shared widths, register map and inter-module structs of the box downscaler.
// ----------------------------------------------------------------------------
package bxd_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_W = 12;
  localparam int SUM_W = 30;

  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FACTOR     = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] pixel;
  } fifo_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [SUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* src/bxd_front.sv */
// ----------------------------------------------------------------------------
// bxd_front
// Two-entry pixel queue between the input channel and the sequencer.
// ----------------------------------------------------------------------------
module bxd_front import bxd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [PIX_W-1:0] pixel_i,
  output logic             in_stall_o,
  input  logic             pop_i,
  output fifo_t            head_o
);

  logic [PIX_W-1:0] buf_q [2];
  logic [1:0]       cnt_q, cnt_d;
  logic             wr_q, rd_q;
  logic             push;

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.pixel = buf_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= pixel_i;
    end
  end

endmodule

/* src/bxd_div.sv */
// ----------------------------------------------------------------------------
// bxd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bxd_div import bxd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CW = $clog2(SUM_W + 1);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [SUM_W-1:0] rem_q, quo_q, dvs_q;
  logic [SUM_W:0]   shifted, diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[SUM_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(SUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], ge};
    end
  end

endmodule

/* src/bxd_back.sv */
// ----------------------------------------------------------------------------
// bxd_back
// Pixel sequencer: geometry, block accumulation, line store and result register.
// ----------------------------------------------------------------------------
module bxd_back import bxd_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] cfg_width_i,
  input  logic [CFG_W-1:0] cfg_height_i,
  input  logic [CFG_W-1:0] cfg_factor_i,
  input  fifo_t            head_i,
  output logic             pop_o,
  output div_req_t         div_req_o,
  input  div_rsp_t         div_rsp_i,
  output logic             out_valid_o,
  output logic [PIX_W-1:0] value_o,
  output logic             last_o,
  input  logic             out_stall_i
);

  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LAT  = 4'd1;
  localparam logic [3:0] S_PROC = 4'd2;
  localparam logic [3:0] S_MEM  = 4'd3;
  localparam logic [3:0] S_GO   = 4'd4;
  localparam logic [3:0] S_WAIT = 4'd5;
  localparam logic [3:0] S_OUT  = 4'd6;
  localparam logic [3:0] S_COL  = 4'd7;
  localparam logic [3:0] S_ADV  = 4'd8;

  localparam logic [2:0] OP_OW  = 3'd0;
  localparam logic [2:0] OP_OH  = 3'd1;
  localparam logic [2:0] OP_XE0 = 3'd2;
  localparam logic [2:0] OP_YE0 = 3'd3;
  localparam logic [2:0] OP_AVG = 3'd4;
  localparam logic [2:0] OP_XE  = 3'd5;
  localparam logic [2:0] OP_YE  = 3'd6;

  logic [3:0]       state_q;
  logic [2:0]       op_q;
  logic [XW-1:0]    fw_q, ow_q, src_x_q, out_col_q, nxe_q, xe0_q, bsx_q;
  logic [YW-1:0]    fh_q, oh_q, src_y_q, out_row_q, nye_q, bsy_q;
  logic             pass_q;
  logic [PIX_W-1:0] pix_q;
  logic [SUM_W-1:0] run_q, sum_q, mul_q, rdata_q;
  logic             last_pend_q;
  logic             out_valid_q, last_q;
  logic [PIX_W-1:0] value_q;

  logic [SUM_W-1:0] mem [DEPTH];

  logic [31:0]      w_ext, h_ext;
  logic [XW-1:0]    fw_d;
  logic [YW-1:0]    fh_d;
  logic [SUM_W-1:0] run_add, new_sum;
  logic [AW-1:0]    col_addr;
  logic             at_x_edge, row_end, at_y_edge, out_free;
  logic [XW-1:0]    bw;
  logic [YW-1:0]    bh;
  logic [XW+YW-1:0] cnt;
  logic [XW:0]      col_p2;
  logic [YW:0]      row_p2;
  logic [2*XW:0]    xprod;
  logic [2*YW:0]    yprod;
  logic [SUM_W-1:0] quo;

  assign w_ext   = 32'(cfg_width_i);
  assign h_ext   = 32'(cfg_height_i);
  assign fw_d    = (w_ext == 32'd0) ? XW'(1) :
                   (w_ext > 32'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(w_ext);
  assign fh_d    = (h_ext == 32'd0) ? YW'(1) :
                   (h_ext > 32'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(h_ext);

  assign run_add   = run_q + SUM_W'(pix_q);
  assign col_addr  = (32'(out_col_q) < 32'(DEPTH)) ? AW'(out_col_q) : AW'(DEPTH - 1);
  assign at_x_edge = ((XW+1)'(src_x_q) + (XW+1)'(1)) == (XW+1)'(nxe_q);
  assign at_y_edge = ((YW+1)'(src_y_q) + (YW+1)'(1)) == (YW+1)'(nye_q);
  assign row_end   = ((XW+1)'(src_x_q) + (XW+1)'(1)) >= (XW+1)'(fw_q);
  assign new_sum   = (src_y_q == bsy_q) ? run_q : (rdata_q + run_q);
  assign bw        = nxe_q - bsx_q;
  assign bh        = nye_q - bsy_q;
  assign cnt       = (XW+YW)'(bw) * (XW+YW)'(bh);
  assign col_p2    = (XW+1)'(out_col_q) + (XW+1)'(2);
  assign row_p2    = (YW+1)'(out_row_q) + (YW+1)'(2);
  assign xprod     = (2*XW+1)'(col_p2) * (2*XW+1)'(fw_q);
  assign yprod     = (2*YW+1)'(row_p2) * (2*YW+1)'(fh_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign quo       = div_rsp_i.quotient;

  assign pop_o       = (state_q == S_IDLE) && head_i.valid;
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

  always_comb begin
    div_req_o.start    = (state_q == S_GO);
    div_req_o.dividend = mul_q;
    div_req_o.divisor  = SUM_W'(ow_q);
    case (op_q)
      OP_OW: begin
        div_req_o.dividend = SUM_W'(fw_q);
        div_req_o.divisor  = SUM_W'(cfg_factor_i);
      end
      OP_OH: begin
        div_req_o.dividend = SUM_W'(fh_q);
        div_req_o.divisor  = SUM_W'(cfg_factor_i);
      end
      OP_XE0: begin
        div_req_o.dividend = SUM_W'(fw_q);
        div_req_o.divisor  = SUM_W'(ow_q);
      end
      OP_YE0: begin
        div_req_o.dividend = SUM_W'(fh_q);
        div_req_o.divisor  = SUM_W'(oh_q);
      end
      OP_AVG: begin
        div_req_o.dividend = sum_q;
        div_req_o.divisor  = (mul_q == '0) ? SUM_W'(1) : mul_q;
      end
      OP_XE: begin
        div_req_o.dividend = mul_q;
        div_req_o.divisor  = SUM_W'(ow_q);
      end
      OP_YE: begin
        div_req_o.dividend = mul_q;
        div_req_o.divisor  = SUM_W'(oh_q);
      end
      default: begin
        div_req_o.dividend = mul_q;
        div_req_o.divisor  = SUM_W'(1);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_PROC) && !pass_q && at_x_edge) begin
      rdata_q <= mem[col_addr];
    end
    if (state_q == S_MEM) begin
      mem[col_addr] <= new_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_OW;
      fw_q        <= XW'(1);
      fh_q        <= YW'(1);
      ow_q        <= '0;
      oh_q        <= '0;
      pass_q      <= 1'b0;
      src_x_q     <= '0;
      src_y_q     <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      nxe_q       <= '0;
      nye_q       <= '0;
      xe0_q       <= '0;
      bsx_q       <= '0;
      bsy_q       <= '0;
      run_q       <= '0;
      sum_q       <= '0;
      mul_q       <= '0;
      last_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (head_i.valid) begin
            state_q <= (src_x_q == '0 && src_y_q == '0) ? S_LAT : S_PROC;
          end
        end
        S_LAT: begin
          fw_q      <= fw_d;
          fh_q      <= fh_d;
          pass_q    <= (cfg_factor_i <= CFG_W'(1));
          run_q     <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
          bsx_q     <= '0;
          bsy_q     <= '0;
          if (cfg_factor_i <= CFG_W'(1)) begin
            ow_q    <= fw_d;
            oh_q    <= fh_d;
            state_q <= S_PROC;
          end else begin
            op_q    <= OP_OW;
            state_q <= S_GO;
          end
        end
        S_PROC: begin
          if (pass_q) begin
            last_pend_q <= row_end &&
                           (((YW+1)'(src_y_q) + (YW+1)'(1)) == (YW+1)'(fh_q));
            sum_q       <= SUM_W'(pix_q);
            state_q     <= S_OUT;
          end else begin
            run_q   <= run_add;
            state_q <= at_x_edge ? S_MEM : S_ADV;
          end
        end
        S_MEM: begin
          sum_q       <= new_sum;
          run_q       <= '0;
          mul_q       <= SUM_W'(cnt);
          last_pend_q <= (((XW+1)'(out_col_q) + (XW+1)'(1)) == (XW+1)'(ow_q)) &&
                         (((YW+1)'(out_row_q) + (YW+1)'(1)) == (YW+1)'(oh_q));
          if (at_y_edge) begin
            op_q    <= OP_AVG;
            state_q <= S_GO;
          end else begin
            state_q <= S_COL;
          end
        end
        S_GO: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (div_rsp_i.done) begin
            case (op_q)
              OP_OW: begin
                ow_q    <= (quo == '0) ? XW'(1) : XW'(quo);
                op_q    <= OP_OH;
                state_q <= S_GO;
              end
              OP_OH: begin
                oh_q    <= (quo == '0) ? YW'(1) : YW'(quo);
                op_q    <= OP_XE0;
                state_q <= S_GO;
              end
              OP_XE0: begin
                xe0_q   <= XW'(quo);
                nxe_q   <= XW'(quo);
                op_q    <= OP_YE0;
                state_q <= S_GO;
              end
              OP_YE0: begin
                nye_q   <= YW'(quo);
                state_q <= S_PROC;
              end
              OP_AVG: begin
                sum_q   <= quo;
                state_q <= S_OUT;
              end
              OP_XE: begin
                nxe_q   <= XW'(quo);
                state_q <= S_ADV;
              end
              OP_YE: begin
                nye_q   <= YW'(quo);
                state_q <= S_IDLE;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= pass_q ? S_ADV : S_COL;
          end
        end
        S_COL: begin
          out_col_q <= out_col_q + XW'(1);
          bsx_q     <= nxe_q;
          if (((XW+1)'(out_col_q) + (XW+1)'(1)) < (XW+1)'(ow_q)) begin
            mul_q   <= SUM_W'(xprod);
            op_q    <= OP_XE;
            state_q <= S_GO;
          end else begin
            state_q <= S_ADV;
          end
        end
        S_ADV: begin
          state_q <= S_IDLE;
          if (row_end) begin
            src_x_q <= '0;
            src_y_q <= (((YW+1)'(src_y_q) + (YW+1)'(1)) >= (YW+1)'(fh_q)) ?
                       '0 : src_y_q + YW'(1);
            if (!pass_q) begin
              out_col_q <= '0;
              bsx_q     <= '0;
              nxe_q     <= xe0_q;
              if (at_y_edge) begin
                out_row_q <= out_row_q + YW'(1);
                bsy_q     <= nye_q;
                if (((YW+1)'(out_row_q) + (YW+1)'(1)) < (YW+1)'(oh_q)) begin
                  mul_q   <= SUM_W'(yprod);
                  op_q    <= OP_YE;
                  state_q <= S_GO;
                end
              end
            end
          end else begin
            src_x_q <= src_x_q + XW'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && head_i.valid) begin
      pix_q <= head_i.pixel;
    end
    if (state_q == S_OUT && out_free) begin
      value_q <= sum_q[PIX_W-1:0];
      last_q  <= last_pend_q;
    end
  end

endmodule

/* src/box_average_downscale.sv */
// ----------------------------------------------------------------------------
// box_average_downscale
// Area-average downscaler for 8-bit gray frames with an APB register port.
// ----------------------------------------------------------------------------
//  channel  | signals                                 | accepted when
//  ---------+-----------------------------------------+--------------------------
//  pixel in | in_valid_i, in_stall_o, pixel_i         | in_valid_i & !in_stall_o
//  result   | out_valid_o, out_stall_i, value_o, last_o | out_valid_o & !out_stall_i
//  config   | psel, penable, pwrite, paddr, pwdata     | psel & penable & pwrite
//
// A pixel runs S_IDLE, S_PROC and S_ADV, plus S_OUT in pass-through. One
// closing a block column adds S_MEM and S_COL and, bar the last column, an edge
// division on the shared one-bit-per-cycle divider; one closing a block adds a
// mean division and S_OUT. A row end on a block edge adds a division, bar the
// last block row; a frame start S_LAT and, if factor > 1, four divisions.
// Reset clears all control state; the line store is written before it is read.
// A two-entry queue takes pixels while the result register waits on out_stall_i.
// ----------------------------------------------------------------------------
module box_average_downscale import bxd_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [PIX_W-1:0] pixel_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PIX_W-1:0] value_o,
  output logic             last_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [CFG_W-1:0] width_q, height_q, factor_q;
  logic [1:0]       reg_idx;
  fifo_t            head;
  logic             pop;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_comb begin
    case (reg_idx)
      REG_SRC_WIDTH:  prdata = 32'(width_q);
      REG_SRC_HEIGHT: prdata = 32'(height_q);
      REG_FACTOR:     prdata = 32'(factor_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(640);
      height_q <= CFG_W'(480);
      factor_q <= CFG_W'(2);
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_SRC_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
        REG_SRC_HEIGHT: height_q <= pwdata[CFG_W-1:0];
        REG_FACTOR:     factor_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  bxd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .pixel_i    (pixel_i),
    .in_stall_o (in_stall_o),
    .pop_i      (pop),
    .head_o     (head)
  );

  bxd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bxd_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .cfg_factor_i (factor_q),
    .head_i       (head),
    .pop_o        (pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .out_valid_o  (out_valid_o),
    .value_o      (value_o),
    .last_o       (last_o),
    .out_stall_i  (out_stall_i)
  );

  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid) else $error("pop from empty queue");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> head.valid) else $error("queue full yet empty");

  a_div_not_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> !div_rsp.done) else $error("divider finished too early");

endmodule
